// ----- rtl/rrd_pkg.sv -----
// Shared widths, types and step functions of the reflect/refract direction unit.
package rrd_pkg;

	localparam int COMP_W    = 16;
	localparam int ETA_W     = 15;
	localparam int FRAC_BITS = 14;
	localparam logic [ETA_W-1:0] RATIO_RESET = 15'd4915;

	localparam int PROD_W  = 2 * COMP_W;           // n_i * d_i
	localparam int DOT_W   = PROD_W + 1;           // sum of three products
	localparam int VEC_W   = 53;                   // unnormalized vectors, Q.42
	localparam int MAG_W   = VEC_W - 1;
	localparam int ED_W    = COMP_W + ETA_W + 1;   // eta * d_i
	localparam int T_W     = 36;                   // eta*cosI - sqrt(cosT2), Q.28
	localparam int RAD_W   = 64;                   // square root radicand
	localparam int ROOT_W  = RAD_W / 2;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int SCL_W   = 31;                   // scaled magnitude, top bit at 30
	localparam int QUO_W   = 16;
	localparam int NUM_W   = 48;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic [ETA_W-1:0]         eta_t;

	typedef struct packed {
		logic [RAD_W-1:0] rem;
		logic [RAD_W-1:0] root;
	} sqrt_st_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_st_t;

	// travels alongside the cosT2 square root
	typedef struct {
		vec_t                     refl [3];
		comp_t                    n    [3];
		logic signed [ED_W-1:0]   ed   [3];
		logic signed [T_W-1:0]    t1;
		logic                     tir;
	} csq_side_t;

	// one digit of the bitwise integer square root, k counts from the top
	function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int unsigned k);
		logic [RAD_W-1:0] bitv;
		logic [RAD_W-1:0] trial;
		sqrt_st_t o;
		bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
		trial = s.root + bitv;
		if (s.rem >= trial) begin
			o.rem  = s.rem - trial;
			o.root = (s.root >> 1) + bitv;
		end else begin
			o.rem  = s.rem;
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	// one quotient bit of restoring division, j is the bit weight
	function automatic div_st_t div_step(div_st_t s, logic [ROOT_W-1:0] len, int unsigned j);
		logic [NUM_W-1:0] dv;
		div_st_t o;
		dv = NUM_W'(len) << j;
		o  = s;
		if (s.rem >= dv) begin
			o.rem = s.rem - dv;
			o.quo = s.quo | (QUO_W'(1) << j);
		end
		return o;
	endfunction

endpackage

// ----- rtl/rrd_ifs.sv -----
// Request channel interfaces: ray input, direction result, ratio write.
interface rrd_in_if;
	logic           valid;
	logic           ready;
	rrd_pkg::comp_t normal_x;
	rrd_pkg::comp_t normal_y;
	rrd_pkg::comp_t normal_z;
	rrd_pkg::comp_t dir_x;
	rrd_pkg::comp_t dir_y;
	rrd_pkg::comp_t dir_z;
	modport source (output valid, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rrd_out_if;
	logic           valid;
	logic           ready;
	rrd_pkg::comp_t refl_x;
	rrd_pkg::comp_t refl_y;
	rrd_pkg::comp_t refl_z;
	rrd_pkg::comp_t refr_x;
	rrd_pkg::comp_t refr_y;
	rrd_pkg::comp_t refr_z;
	logic           total_internal;
	modport source (output valid, refl_x, refl_y, refl_z, refr_x, refr_y, refr_z,
		total_internal, input ready);
	modport sink (input valid, refl_x, refl_y, refl_z, refr_x, refr_y, refr_z,
		total_internal, output ready);
endinterface

interface rrd_cfg_if;
	logic          valid;
	logic          ready;
	rrd_pkg::eta_t index_ratio;
	modport source (output valid, index_ratio, input ready);
	modport sink (input valid, index_ratio, output ready);
endinterface

// ----- rtl/rrd_front.sv -----
// Front stages: dot product, reflected vector, cosT2 and square root radicand.
module rrd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  rrd_pkg::comp_t             n_in [3],
	input  rrd_pkg::comp_t             d_in [3],
	input  rrd_pkg::eta_t              eta,
	output logic                       out_valid,
	output logic [rrd_pkg::RAD_W-1:0]  rad,
	output rrd_pkg::csq_side_t         side
);

	localparam int EC_W    = rrd_pkg::ETA_W + 1 + rrd_pkg::DOT_W;
	localparam int DN_W    = rrd_pkg::DOT_W + rrd_pkg::COMP_W;
	localparam int C2_W    = rrd_pkg::RAD_W - 2 * rrd_pkg::FRAC_BITS;
	localparam int SIN_W   = C2_W + 2;
	localparam int E2_W    = 2 * rrd_pkg::ETA_W;
	localparam int ETA2_W  = E2_W + 1 - rrd_pkg::FRAC_BITS - 1;
	localparam int PT_W    = ETA2_W + 1 + SIN_W;
	localparam int CT_W    = PT_W + 1;
	localparam int ONE_POS = 2 * rrd_pkg::FRAC_BITS;   // 1.0 in Q.28
	localparam int RAD_SH  = 10;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	rrd_pkg::comp_t                 n_s1 [3], d_s1 [3];
	logic signed [rrd_pkg::PROD_W-1:0] p_s1 [3];

	rrd_pkg::comp_t                 n_s2 [3], d_s2 [3];
	logic signed [rrd_pkg::DOT_W-1:0]  dot_s2;

	rrd_pkg::comp_t                 n_s3 [3];
	rrd_pkg::vec_t                  refl_s3 [3];
	logic signed [rrd_pkg::ED_W-1:0]   ed_s3 [3];
	logic [rrd_pkg::RAD_W-1:0]      csq_s3;
	logic [E2_W-1:0]                e2_s3;
	logic signed [EC_W-1:0]         ec_s3;

	rrd_pkg::comp_t                 n_s4 [3];
	rrd_pkg::vec_t                  refl_s4 [3];
	logic signed [rrd_pkg::ED_W-1:0]   ed_s4 [3];
	logic signed [SIN_W-1:0]        sin2_s4;
	logic [ETA2_W-1:0]              eta2_s4;
	logic signed [rrd_pkg::T_W-1:0]    t1_s4;

	rrd_pkg::comp_t                 n_s5 [3];
	rrd_pkg::vec_t                  refl_s5 [3];
	logic signed [rrd_pkg::ED_W-1:0]   ed_s5 [3];
	logic signed [PT_W-1:0]         pt_s5;
	logic signed [rrd_pkg::T_W-1:0]    t1_s5;

	logic [rrd_pkg::RAD_W-1:0]      rad_s6;
	rrd_pkg::csq_side_t             side_s6;

	// stage 3 terms
	logic signed [rrd_pkg::ETA_W:0]    eta_sx;
	logic signed [rrd_pkg::DOT_W-1:0]  cos_i;
	logic [rrd_pkg::PROD_W-1:0]     dabs;
	logic signed [DN_W-1:0]         dn [3];
	rrd_pkg::vec_t                  refl_c [3];
	logic signed [rrd_pkg::ED_W-1:0]   ed_c [3];
	logic signed [EC_W-1:0]         ec_c;

	// stage 4 terms
	logic [rrd_pkg::RAD_W-1:0]      csr;
	logic [E2_W:0]                  e2r;
	logic [EC_W-1:0]                ecm;
	logic [rrd_pkg::T_W-2:0]        ecr;
	logic signed [rrd_pkg::T_W-1:0]    t1_c;
	logic signed [SIN_W-1:0]        sin2_c;

	// stage 6 terms
	logic signed [CT_W-1:0]         cos_t2;
	logic                           tir_c;

	always_comb begin
		eta_sx = signed'({1'b0, eta});
		cos_i  = -dot_s2;
		dabs   = rrd_pkg::PROD_W'(dot_s2 < 0 ? -dot_s2 : dot_s2);
		ec_c   = eta_sx * cos_i;
		for (int i = 0; i < 3; i++) begin
			dn[i]     = dot_s2 * n_s2[i];
			refl_c[i] = (rrd_pkg::vec_t'(d_s2[i]) <<< ONE_POS) - (rrd_pkg::vec_t'(dn[i]) <<< 1);
			ed_c[i]   = eta_sx * d_s2[i];
		end
	end

	always_comb begin
		csr    = csq_s3 + (rrd_pkg::RAD_W'(1) << (ONE_POS - 1));
		sin2_c = (SIN_W'(1) <<< ONE_POS) - signed'({2'b00, csr[rrd_pkg::RAD_W-1:ONE_POS]});
		e2r    = {1'b0, e2_s3} + ((E2_W + 1)'(1) << (rrd_pkg::FRAC_BITS - 1));
		ecm    = EC_W'(ec_s3 < 0 ? -ec_s3 : ec_s3) + (EC_W'(1) << (rrd_pkg::FRAC_BITS - 1));
		ecr    = ecm[EC_W-1:rrd_pkg::FRAC_BITS];
		t1_c   = ec_s3 < 0 ? -signed'({1'b0, ecr}) : signed'({1'b0, ecr});
	end

	always_comb begin
		cos_t2 = (CT_W'(1) <<< (3 * rrd_pkg::FRAC_BITS)) - CT_W'(pt_s5);
		tir_c  = cos_t2 <= 0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s1[i]    <= n_in[i];
				d_s1[i]    <= d_in[i];
				p_s1[i]    <= n_in[i] * d_in[i];
				n_s2[i]    <= n_s1[i];
				d_s2[i]    <= d_s1[i];
				n_s3[i]    <= n_s2[i];
				refl_s3[i] <= refl_c[i];
				ed_s3[i]   <= ed_c[i];
				n_s4[i]    <= n_s3[i];
				refl_s4[i] <= refl_s3[i];
				ed_s4[i]   <= ed_s3[i];
				n_s5[i]    <= n_s4[i];
				refl_s5[i] <= refl_s4[i];
				ed_s5[i]   <= ed_s4[i];
				side_s6.n[i]    <= n_s5[i];
				side_s6.refl[i] <= refl_s5[i];
				side_s6.ed[i]   <= ed_s5[i];
			end
			dot_s2  <= rrd_pkg::DOT_W'(p_s1[0]) + rrd_pkg::DOT_W'(p_s1[1])
				+ rrd_pkg::DOT_W'(p_s1[2]);
			csq_s3  <= rrd_pkg::RAD_W'(dabs) * rrd_pkg::RAD_W'(dabs);
			e2_s3   <= E2_W'(eta) * E2_W'(eta);
			ec_s3   <= ec_c;
			sin2_s4 <= sin2_c;
			eta2_s4 <= e2r[rrd_pkg::FRAC_BITS +: ETA2_W];
			t1_s4   <= t1_c;
			pt_s5   <= signed'({1'b0, eta2_s4}) * sin2_s4;
			t1_s5   <= t1_s4;
			side_s6.t1  <= t1_s5;
			side_s6.tir <= tir_c;
			rad_s6  <= tir_c ? '0 : (rrd_pkg::RAD_W'(cos_t2) << RAD_SH);
		end
	end

	assign out_valid = v_s6;
	assign rad       = rad_s6;
	assign side      = side_s6;

endmodule

// ----- rtl/rrd_csqrt.sv -----
// sqrt(cosT2) pipeline and assembly of the unnormalized refracted vector.
module rrd_csqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [rrd_pkg::RAD_W-1:0]  rad,
	input  rrd_pkg::csq_side_t         side_in,
	output logic                       out_valid,
	output rrd_pkg::vec_t              refl [3],
	output rrd_pkg::vec_t              refr [3],
	output logic                       tir
);

	localparam int NT_W = rrd_pkg::COMP_W + rrd_pkg::T_W;

	logic                vl_s [1:rrd_pkg::SQRT_STEPS];
	rrd_pkg::sqrt_st_t   sq_s [1:rrd_pkg::SQRT_STEPS];
	rrd_pkg::csq_side_t  sd_s [1:rrd_pkg::SQRT_STEPS];

	genvar k;
	generate
		for (k = 0; k < rrd_pkg::SQRT_STEPS; k++) begin : g_step
			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) vl_s[1] <= 1'b0;
					else if (en) vl_s[1] <= in_valid;
				end
				always_ff @(posedge clk) begin
					if (en) begin
						sq_s[1] <= rrd_pkg::sqrt_step('{rem: rad, root: '0}, 0);
						sd_s[1] <= side_in;
					end
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) vl_s[k+1] <= 1'b0;
					else if (en) vl_s[k+1] <= vl_s[k];
				end
				always_ff @(posedge clk) begin
					if (en) begin
						sq_s[k+1] <= rrd_pkg::sqrt_step(sq_s[k], k);
						sd_s[k+1] <= sd_s[k];
					end
				end
			end
		end
	endgenerate

	logic                            v_sa, v_sb;
	logic signed [rrd_pkg::T_W-1:0]  t_sa;
	rrd_pkg::csq_side_t              sd_sa;
	rrd_pkg::vec_t                   refl_sb [3], refr_sb [3];
	logic                            tir_sb;

	logic [rrd_pkg::ROOT_W-1:0]      root;
	logic signed [NT_W-1:0]          nt [3];
	rrd_pkg::vec_t                   refr_c [3];

	always_comb begin
		root = sq_s[rrd_pkg::SQRT_STEPS].root[rrd_pkg::ROOT_W-1:0];
		for (int i = 0; i < 3; i++) begin
			nt[i]     = sd_sa.n[i] * t_sa;
			refr_c[i] = sd_sa.tir ? '0 :
				(rrd_pkg::vec_t'(sd_sa.ed[i]) <<< rrd_pkg::FRAC_BITS) + rrd_pkg::vec_t'(nt[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
			v_sb <= 1'b0;
		end else if (en) begin
			v_sa <= vl_s[rrd_pkg::SQRT_STEPS];
			v_sb <= v_sa;
		end
	end

	// root is Q.26, scaled to Q.28
	always_ff @(posedge clk) begin
		if (en) begin
			t_sa   <= sd_s[rrd_pkg::SQRT_STEPS].t1 - signed'({2'b00, root, 2'b00});
			sd_sa  <= sd_s[rrd_pkg::SQRT_STEPS];
			tir_sb <= sd_sa.tir;
			for (int i = 0; i < 3; i++) begin
				refl_sb[i] <= sd_sa.refl[i];
				refr_sb[i] <= refr_c[i];
			end
		end
	end

	assign out_valid = v_sb;
	assign refl      = refl_sb;
	assign refr      = refr_sb;
	assign tir       = tir_sb;

endmodule

// ----- rtl/rrd_norm.sv -----
// Normalizes both vectors: scale, sum of squares, square root, rounded divide.
module rrd_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  rrd_pkg::vec_t   vin [2][3],
	input  logic            tir_in,
	output logic            out_valid,
	output rrd_pkg::comp_t  res [2][3],
	output logic            tir_out
);

	localparam int POS_W = $clog2(rrd_pkg::MAG_W);
	localparam int TOP   = rrd_pkg::SCL_W - 1;
	localparam int SQ_W  = 2 * rrd_pkg::SCL_W;
	localparam logic [rrd_pkg::QUO_W:0] SAT_NEG = (rrd_pkg::QUO_W + 1)'(1) << (rrd_pkg::COMP_W - 1);
	localparam logic [rrd_pkg::QUO_W:0] SAT_POS = SAT_NEG - 1'b1;

	typedef struct {
		logic [rrd_pkg::SCL_W-1:0] a    [2][3];
		logic                      neg  [2][3];
		logic                      zero [2];
		logic                      tir;
	} nside_t;

	// magnitude stage
	logic                      v_s1;
	logic [rrd_pkg::MAG_W-1:0] mag_s1 [2][3];
	logic                      neg_s1 [2][3];
	logic [rrd_pkg::MAG_W-1:0] or_s1  [2];
	logic                      tir_s1;

	// leading one
	logic                      v_s2;
	logic [rrd_pkg::MAG_W-1:0] mag_s2 [2][3];
	logic                      neg_s2 [2][3];
	logic [POS_W-1:0]          pos_s2 [2];
	logic                      zero_s2 [2];
	logic                      tir_s2;

	logic                      v_s3, v_s4, v_s5;
	nside_t                    ns_s3, ns_s4, ns_s5;
	logic [SQ_W-1:0]           sq_s4  [2][3];
	logic [rrd_pkg::RAD_W-1:0] sum_s5 [2];

	logic [rrd_pkg::MAG_W-1:0] mag_c [2][3];
	logic [POS_W-1:0]          pos_c [2];
	logic [rrd_pkg::SCL_W-1:0] a_c   [2][3];

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 3; i++)
				mag_c[v][i] = rrd_pkg::MAG_W'(vin[v][i] < 0 ? -vin[v][i] : vin[v][i]);
			pos_c[v] = '0;
			for (int b = 0; b < rrd_pkg::MAG_W; b++)
				if (or_s1[v][b]) pos_c[v] = POS_W'(b);
			for (int i = 0; i < 3; i++) begin
				if (pos_s2[v] > POS_W'(TOP))
					a_c[v][i] = rrd_pkg::SCL_W'(mag_s2[v][i] >> (pos_s2[v] - POS_W'(TOP)));
				else
					a_c[v][i] = rrd_pkg::SCL_W'(mag_s2[v][i] << (POS_W'(TOP) - pos_s2[v]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s1 <= tir_in;
			tir_s2 <= tir_s1;
			ns_s3.tir <= tir_s2;
			ns_s4 <= ns_s3;
			ns_s5 <= ns_s4;
			for (int v = 0; v < 2; v++) begin
				or_s1[v]      <= mag_c[v][0] | mag_c[v][1] | mag_c[v][2];
				pos_s2[v]     <= pos_c[v];
				zero_s2[v]    <= or_s1[v] == '0;
				ns_s3.zero[v] <= zero_s2[v];
				sum_s5[v]     <= rrd_pkg::RAD_W'(sq_s4[v][0]) + rrd_pkg::RAD_W'(sq_s4[v][1])
					+ rrd_pkg::RAD_W'(sq_s4[v][2]);
				for (int i = 0; i < 3; i++) begin
					mag_s1[v][i]   <= mag_c[v][i];
					neg_s1[v][i]   <= vin[v][i] < 0;
					mag_s2[v][i]   <= mag_s1[v][i];
					neg_s2[v][i]   <= neg_s1[v][i];
					ns_s3.a[v][i]   <= a_c[v][i];
					ns_s3.neg[v][i] <= neg_s2[v][i];
					sq_s4[v][i]    <= SQ_W'(ns_s3.a[v][i]) * SQ_W'(ns_s3.a[v][i]);
				end
			end
		end
	end

	// square root of the sum of squares
	logic              vl_q  [1:rrd_pkg::SQRT_STEPS];
	rrd_pkg::sqrt_st_t sqr_q [1:rrd_pkg::SQRT_STEPS][2];
	nside_t            nsq_q [1:rrd_pkg::SQRT_STEPS];

	genvar k;
	generate
		for (k = 0; k < rrd_pkg::SQRT_STEPS; k++) begin : g_sqrt
			if (k == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) vl_q[1] <= 1'b0;
					else if (en) vl_q[1] <= v_s5;
				end
				always_ff @(posedge clk) begin
					if (en) begin
						for (int v = 0; v < 2; v++)
							sqr_q[1][v] <= rrd_pkg::sqrt_step('{rem: sum_s5[v], root: '0}, 0);
						nsq_q[1] <= ns_s5;
					end
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) vl_q[k+1] <= 1'b0;
					else if (en) vl_q[k+1] <= vl_q[k];
				end
				always_ff @(posedge clk) begin
					if (en) begin
						for (int v = 0; v < 2; v++)
							sqr_q[k+1][v] <= rrd_pkg::sqrt_step(sqr_q[k][v], k);
						nsq_q[k+1] <= nsq_q[k];
					end
				end
			end
		end
	endgenerate

	// rounded divide: (a * 2^14 + len/2) / len
	logic                       v_d0;
	rrd_pkg::div_st_t           dv_d0 [2][3];
	logic [rrd_pkg::ROOT_W-1:0] len_d0 [2];
	nside_t                     ns_d0;
	logic [rrd_pkg::ROOT_W-1:0] len_c [2];

	always_comb begin
		for (int v = 0; v < 2; v++)
			len_c[v] = sqr_q[rrd_pkg::SQRT_STEPS][v].root[rrd_pkg::ROOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_d0 <= 1'b0;
		else if (en) v_d0 <= vl_q[rrd_pkg::SQRT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ns_d0 <= nsq_q[rrd_pkg::SQRT_STEPS];
			for (int v = 0; v < 2; v++) begin
				len_d0[v] <= len_c[v];
				for (int i = 0; i < 3; i++) begin
					dv_d0[v][i].rem <= (rrd_pkg::NUM_W'(nsq_q[rrd_pkg::SQRT_STEPS].a[v][i])
						<< rrd_pkg::FRAC_BITS) + rrd_pkg::NUM_W'(len_c[v] >> 1);
					dv_d0[v][i].quo <= '0;
				end
			end
		end
	end

	logic                       vd_q  [1:rrd_pkg::QUO_W];
	rrd_pkg::div_st_t           dv_q  [1:rrd_pkg::QUO_W][2][3];
	logic [rrd_pkg::ROOT_W-1:0] len_q [1:rrd_pkg::QUO_W][2];
	nside_t                     nsd_q [1:rrd_pkg::QUO_W];

	genvar m;
	generate
		for (m = 0; m < rrd_pkg::QUO_W; m++) begin : g_div
			if (m == 0) begin : g_first
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) vd_q[1] <= 1'b0;
					else if (en) vd_q[1] <= v_d0;
				end
				always_ff @(posedge clk) begin
					if (en) begin
						for (int v = 0; v < 2; v++) begin
							len_q[1][v] <= len_d0[v];
							for (int i = 0; i < 3; i++)
								dv_q[1][v][i] <= rrd_pkg::div_step(dv_d0[v][i], len_d0[v],
									rrd_pkg::QUO_W - 1);
						end
						nsd_q[1] <= ns_d0;
					end
				end
			end else begin : g_next
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) vd_q[m+1] <= 1'b0;
					else if (en) vd_q[m+1] <= vd_q[m];
				end
				always_ff @(posedge clk) begin
					if (en) begin
						for (int v = 0; v < 2; v++) begin
							len_q[m+1][v] <= len_q[m][v];
							for (int i = 0; i < 3; i++)
								dv_q[m+1][v][i] <= rrd_pkg::div_step(dv_q[m][v][i], len_q[m][v],
									rrd_pkg::QUO_W - 1 - m);
						end
						nsd_q[m+1] <= nsd_q[m];
					end
				end
			end
		end
	endgenerate

	// saturate, restore sign, zero vectors give zero
	logic                 v_sf;
	rrd_pkg::comp_t       res_sf [2][3];
	logic                 tir_sf;
	logic [rrd_pkg::QUO_W:0] qs [2][3];
	rrd_pkg::comp_t       res_c [2][3];

	always_comb begin
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 3; i++) begin
				qs[v][i] = {1'b0, dv_q[rrd_pkg::QUO_W][v][i].quo};
				if (nsd_q[rrd_pkg::QUO_W].neg[v][i]) begin
					if (qs[v][i] > SAT_NEG) qs[v][i] = SAT_NEG;
					res_c[v][i] = rrd_pkg::comp_t'(-qs[v][i]);
				end else begin
					if (qs[v][i] > SAT_POS) qs[v][i] = SAT_POS;
					res_c[v][i] = rrd_pkg::comp_t'(qs[v][i]);
				end
				if (nsd_q[rrd_pkg::QUO_W].zero[v]) res_c[v][i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sf <= 1'b0;
		else if (en) v_sf <= vd_q[rrd_pkg::QUO_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sf <= res_c;
			tir_sf <= nsd_q[rrd_pkg::QUO_W].tir;
		end
	end

	assign out_valid = v_sf;
	assign res       = res_sf;
	assign tir_out   = tir_sf;

endmodule

// ----- rtl/reflect_refract_direction.sv -----
// Pipeline: 95 register stages from the ray input to the result on res.
// Throughput: one request per cycle; the whole pipeline shares one enable, held back
//   only while the final output register is full and not taken.
// Stage split: 6 front stages, 32+2 for sqrt(cosT2) and refraction, 55 for the
//   two normalizers (scale, squares, 32-step root, 16-step divide, saturate).
// Reset: arst_n clears every valid bit and loads eta with 4915 (about 0.3).
module reflect_refract_direction (
	input  logic      clk,
	input  logic      arst_n,
	rrd_in_if.sink    ray,
	rrd_out_if.source res,
	rrd_cfg_if.sink   cfg
);

	// pipeline moves whenever the output register is empty or being drained
	logic          en;
	logic          out_valid;
	rrd_pkg::eta_t eta_q;

	assign en        = !out_valid || res.ready;
	assign ray.ready = en;
	assign cfg.ready = 1'b1;

	// index ratio; the user must write it only while no request is in flight, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eta_q <= rrd_pkg::RATIO_RESET;
		else if (cfg.valid && cfg.ready) eta_q <= cfg.index_ratio;
	end

	rrd_pkg::comp_t n_in [3];
	rrd_pkg::comp_t d_in [3];

	assign n_in[0] = ray.normal_x;
	assign n_in[1] = ray.normal_y;
	assign n_in[2] = ray.normal_z;
	assign d_in[0] = ray.dir_x;
	assign d_in[1] = ray.dir_y;
	assign d_in[2] = ray.dir_z;

	// front: n.d, d - 2(n.d)n, cosT2 and TIR decision
	logic                       fr_valid;
	logic [rrd_pkg::RAD_W-1:0]  fr_rad;
	rrd_pkg::csq_side_t         fr_side;

	rrd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ray.valid),
		.n_in      (n_in),
		.d_in      (d_in),
		.eta       (eta_q),
		.out_valid (fr_valid),
		.rad       (fr_rad),
		.side      (fr_side)
	);

	// sqrt(cosT2), then eta*d + n*(eta*cosI - sqrt(cosT2)); zeroed on TIR
	logic          cs_valid;
	rrd_pkg::vec_t cs_refl [3];
	rrd_pkg::vec_t cs_refr [3];
	logic          cs_tir;

	rrd_csqrt u_csqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.rad       (fr_rad),
		.side_in   (fr_side),
		.out_valid (cs_valid),
		.refl      (cs_refl),
		.refr      (cs_refr),
		.tir       (cs_tir)
	);

	// vector 0 is the reflection, vector 1 the refraction
	rrd_pkg::vec_t  nm_in  [2][3];
	rrd_pkg::comp_t nm_res [2][3];
	logic           nm_tir;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nm_in[0][i] = cs_refl[i];
			nm_in[1][i] = cs_refr[i];
		end
	end

	rrd_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cs_valid),
		.vin       (nm_in),
		.tir_in    (cs_tir),
		.out_valid (out_valid),
		.res       (nm_res),
		.tir_out   (nm_tir)
	);

	assign res.valid          = out_valid;
	assign res.refl_x         = nm_res[0][0];
	assign res.refl_y         = nm_res[0][1];
	assign res.refl_z         = nm_res[0][2];
	assign res.refr_x         = nm_res[1][0];
	assign res.refr_y         = nm_res[1][1];
	assign res.refr_z         = nm_res[1][2];
	assign res.total_internal = nm_tir;

endmodule

// ----- sim/reflect_refract_direction_test.sv -----
// Self-checking testbench for the reflect/refract direction unit.
module reflect_refract_direction_test;

	localparam int LATENCY = 95;

	typedef struct {
		rrd_pkg::comp_t n [3];
		rrd_pkg::comp_t d [3];
	} ray_t;

	typedef struct {
		rrd_pkg::comp_t refl [3];
		rrd_pkg::comp_t refr [3];
		logic           tir;
	} dirs_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rrd_in_if  ray_ch ();
	rrd_out_if res_ch ();
	rrd_cfg_if cfg_ch ();

	reflect_refract_direction DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.ray    (ray_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// rays waiting to be offered, and directions still owed by the block
	ray_t          ray_queue [$];
	dirs_t         dirs_owed [$];
	rrd_pkg::eta_t eta_model = rrd_pkg::RATIO_RESET;
	bit            failed = 1'b0;
	bit            ray_sent = 1'b0;
	int            send_idle_pct = 18;
	int            recv_idle_pct = 86;
	bit            recv_hold = 1'b0;
	bit            hold_go = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bitwise floor square root
	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// scale to [2^30,2^31), divide by floor length, round, saturate
	function automatic void to_unit(input longint v [3], output rrd_pkg::comp_t o [3]);
		longint unsigned a [3];
		longint unsigned m, sum, len, q;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = mag(v[i]);
			if (a[i] > m)
				m = a[i];
		end
		if (m == 0) begin
			for (int i = 0; i < 3; i++)
				o[i] = '0;
			return;
		end
		while (m >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++)
				a[i] >>= 1;
			m >>= 1;
		end
		while (m < (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++)
				a[i] <<= 1;
			m <<= 1;
		end
		for (int i = 0; i < 3; i++)
			sum += a[i] * a[i];
		len = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (a[i] * 64'd16384 + len / 2) / len;
			if (v[i] < 0) begin
				if (q > 32768)
					q = 32768;
				o[i] = rrd_pkg::comp_t'(-longint'(q));
			end else begin
				if (q > 32767)
					q = 32767;
				o[i] = rrd_pkg::comp_t'(q);
			end
		end
	endfunction

	function automatic dirs_t predict_directions(ray_t r, rrd_pkg::eta_t eta_reg);
		dirs_t res;
		longint n [3], d [3], refl [3], refr [3];
		longint dot, cos_i, sin2, cos_t2, eta, eta2, s28, t, et;
		longint unsigned c2, em;
		eta = longint'(eta_reg);
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			n[i] = longint'(r.n[i]);
			d[i] = longint'(r.d[i]);
			dot += n[i] * d[i];
		end
		for (int i = 0; i < 3; i++)
			refl[i] = d[i] * (64'sd1 <<< 28) - 2 * dot * n[i];
		to_unit(refl, res.refl);

		// Snell: cosT2 in Q.42 from rounded cosI^2 and eta^2
		cos_i = -dot;
		c2 = mag(cos_i);
		c2 = (c2 * c2 + (64'd1 << 27)) >> 28;
		sin2 = (64'sd1 <<< 28) - longint'(c2);
		eta2 = (eta * eta + 8192) >>> 14;
		cos_t2 = (64'sd1 <<< 42) - eta2 * sin2;
		res.tir = cos_t2 <= 0;
		if (res.tir) begin
			for (int i = 0; i < 3; i++)
				res.refr[i] = '0;
		end else begin
			s28 = longint'(floor_sqrt(longint'(cos_t2) << 10)) * 4;
			et = eta * cos_i;
			em = (mag(et) + 64'd8192) >> 14;
			t = (et < 0 ? -longint'(em) : longint'(em)) - s28;
			for (int i = 0; i < 3; i++)
				refr[i] = eta * d[i] * 16384 + n[i] * t;
			to_unit(refr, res.refr);
		end
		return res;
	endfunction

	// sender: at the falling edge, drop a taken ray and maybe offer the next pending one
	always @(negedge clk) begin
		if (ray_sent || !ray_ch.valid) begin
			ray_sent = 1'b0;
			if (arst_n && ray_queue.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				ray_ch.valid    <= 1'b1;
				ray_ch.normal_x <= ray_queue[0].n[0];
				ray_ch.normal_y <= ray_queue[0].n[1];
				ray_ch.normal_z <= ray_queue[0].n[2];
				ray_ch.dir_x    <= ray_queue[0].d[0];
				ray_ch.dir_y    <= ray_queue[0].d[1];
				ray_ch.dir_z    <= ray_queue[0].d[2];
			end else begin
				ray_ch.valid <= 1'b0;
			end
		end
	end

	// receiver readiness
	always @(negedge clk)
		res_ch.ready <= !recv_hold && $urandom_range(99) >= recv_idle_pct;

	// long receiver hold-off so the pipeline fills and backs up into the input
	initial begin
		wait (hold_go);
		recv_hold = 1'b1;
		repeat (400) @(posedge clk);
		recv_hold = 1'b0;
	end

	// accepted requests: predict on ray acceptance, check on result acceptance
	always @(posedge clk) begin
		dirs_t exp_d;
		ray_t  r;
		if (cfg_ch.valid && cfg_ch.ready)
			eta_model = cfg_ch.index_ratio;
		if (ray_ch.valid && ray_ch.ready) begin
			r = ray_queue.pop_front();
			dirs_owed.push_back(predict_directions(r, eta_model));
			ray_sent = 1'b1;
		end
		if (res_ch.valid && res_ch.ready) begin
			if (dirs_owed.size() == 0) begin
				$error("result with no ray outstanding");
				failed = 1'b1;
			end else begin
				exp_d = dirs_owed.pop_front();
				if (res_ch.refl_x !== exp_d.refl[0]) begin
					$error("refl_x exp %0d got %0d", exp_d.refl[0], res_ch.refl_x);
					failed = 1'b1;
				end
				if (res_ch.refl_y !== exp_d.refl[1]) begin
					$error("refl_y exp %0d got %0d", exp_d.refl[1], res_ch.refl_y);
					failed = 1'b1;
				end
				if (res_ch.refl_z !== exp_d.refl[2]) begin
					$error("refl_z exp %0d got %0d", exp_d.refl[2], res_ch.refl_z);
					failed = 1'b1;
				end
				if (res_ch.refr_x !== exp_d.refr[0]) begin
					$error("refr_x exp %0d got %0d", exp_d.refr[0], res_ch.refr_x);
					failed = 1'b1;
				end
				if (res_ch.refr_y !== exp_d.refr[1]) begin
					$error("refr_y exp %0d got %0d", exp_d.refr[1], res_ch.refr_y);
					failed = 1'b1;
				end
				if (res_ch.refr_z !== exp_d.refr[2]) begin
					$error("refr_z exp %0d got %0d", exp_d.refr[2], res_ch.refr_z);
					failed = 1'b1;
				end
				if (res_ch.total_internal !== exp_d.tir) begin
					$error("total_internal exp %0b got %0b", exp_d.tir,
						res_ch.total_internal);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic add_ray(int nx, int ny, int nz, int dx, int dy, int dz);
		ray_t r;
		r.n[0] = rrd_pkg::comp_t'(nx);
		r.n[1] = rrd_pkg::comp_t'(ny);
		r.n[2] = rrd_pkg::comp_t'(nz);
		r.d[0] = rrd_pkg::comp_t'(dx);
		r.d[1] = rrd_pkg::comp_t'(dy);
		r.d[2] = rrd_pkg::comp_t'(dz);
		ray_queue.push_back(r);
	endtask

	// mostly near-unit geometry, the rest raw full-range noise
	task automatic add_random_ray();
		int c [6];
		int sel;
		sel = $urandom_range(9);
		for (int k = 0; k < 6; k++) begin
			if (sel < 3)
				c[k] = int'($urandom_range(65535)) - 32768;
			else
				c[k] = int'($urandom_range(18000)) - 9000;
		end
		if (sel >= 3 && sel < 6) begin
			// axis-aligned unit normal, random sign
			c[0] = 0;
			c[1] = 0;
			c[2] = 0;
			c[$urandom_range(2)] = $urandom_range(1) ? 16384 : -16384;
		end
		add_ray(c[0], c[1], c[2], c[3], c[4], c[5]);
	endtask

	// write eta with the block idle: all rays taken and all directions returned
	task automatic write_ratio(rrd_pkg::eta_t v);
		wait (ray_queue.size() == 0 && dirs_owed.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.index_ratio <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		rrd_pkg::eta_t ratios [6];
		ray_ch.valid    = 1'b0;
		ray_ch.normal_x = '0;
		ray_ch.normal_y = '0;
		ray_ch.normal_z = '0;
		ray_ch.dir_x    = '0;
		ray_ch.dir_y    = '0;
		ray_ch.dir_z    = '0;
		res_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index_ratio = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, at the reset ratio: zero vectors, extremes, grazing, head-on
		add_ray(0, 0, 0, 0, 0, 0);
		add_ray(-32768, -32768, -32768, -32768, -32768, -32768);
		add_ray(32767, 32767, 32767, 32767, 32767, 32767);
		add_ray(32767, -32768, 32767, -32768, 32767, -32768);
		add_ray(0, 0, 16384, 0, 0, -16384);
		add_ray(0, 16384, 0, 16384, 0, 0);
		add_ray(16384, 0, 0, 0, 0, 0);
		add_ray(0, 0, 0, 0, 16384, 0);
		add_ray(0, 0, 16384, 11585, 0, -11585);
		add_ray(0, 0, -16384, 1, 1, 16384);
		add_ray(1, -1, 1, -1, 1, -1);
		add_ray(-16384, 0, 0, 16384, 0, 0);

		ratios[0] = rrd_pkg::RATIO_RESET;
		ratios[1] = 15'd32767;
		ratios[2] = 15'd0;
		ratios[3] = 15'd16384;
		ratios[4] = 15'd24576;
		ratios[5] = rrd_pkg::eta_t'($urandom_range(32767));
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				send_idle_pct = 86;
				recv_idle_pct = 18;
			end else if (p == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_ratio(ratios[p]);
			// grazing rays with eta above one exercise internal reflection
			if (p == 1) begin
				add_ray(0, 0, 16384, 16000, 0, -3000);
				add_ray(0, 0, 16384, 0, 16384, 0);
			end
			for (int k = 0; k < 180; k++)
				add_random_ray();
			if (p == 4)
				hold_go = 1'b1;
		end

		wait (ray_queue.size() == 0 && dirs_owed.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (!failed)
			$display("reflect_refract_direction_test: PASS");
		else
			$display("reflect_refract_direction_test: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("reflect_refract_direction_test: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/rrd_pkg.sv
rtl/rrd_ifs.sv
rtl/rrd_front.sv
rtl/rrd_csqrt.sv
rtl/rrd_norm.sv
rtl/reflect_refract_direction.sv
sim/reflect_refract_direction_test.sv
